>>> rtl/hbrp_pkg.sv
package hbrp_pkg;

  // Field widths of the header and result channels.
  localparam int VAL_W    = 63;
  localparam int NUM_W    = 63;
  localparam int CHAR_W   = 8;
  localparam int COUNT_W  = 8;
  localparam int KIND_W   = 2;

  // Configuration port.
  localparam int CFG_W     = 63;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_RES_LEN     = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_RANGE_LIMIT = CFG_IDX_W'(1);

  localparam logic [COUNT_W-1:0] RANGE_LIMIT_RST = COUNT_W'(16);

  // Result kinds.
  localparam logic [KIND_W-1:0] KIND_RANGE  = KIND_W'(0);
  localparam logic [KIND_W-1:0] KIND_OK     = KIND_W'(1);
  localparam logic [KIND_W-1:0] KIND_SYNTAX = KIND_W'(2);
  localparam logic [KIND_W-1:0] KIND_UNSAT  = KIND_W'(3);

  // Characters.
  localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_COMMA = 8'h2C;
  localparam logic [CHAR_W-1:0] CH_DASH  = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
  localparam logic [CHAR_W-1:0] CH_UP_A  = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UP_Z  = 8'h5A;
  localparam logic [CHAR_W-1:0] CH_CASE  = 8'h20;

  localparam int PREFIX_LEN = 6;
  localparam int POS_W      = 3;

  // Result queue.
  localparam int OUT_DEPTH = 4;
  localparam int OUT_AW    = 2;
  localparam int OUT_CW    = 3;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [VAL_W-1:0]   range_start;
    logic [VAL_W-1:0]   range_stop;
    logic [COUNT_W-1:0] range_number;
    logic               run_last;
  } result_t;

  // Expected text of the lower-cased prefix "bytes=".
  function automatic logic [CHAR_W-1:0] prefix_char(input logic [POS_W-1:0] pos);
    logic [CHAR_W-1:0] c;
    case (pos)
      3'd0:    c = 8'h62;
      3'd1:    c = 8'h79;
      3'd2:    c = 8'h74;
      3'd3:    c = 8'h65;
      3'd4:    c = 8'h73;
      3'd5:    c = 8'h3D;
      default: c = CH_NUL;
    endcase
    return c;
  endfunction

endpackage

>>> rtl/hbrp_if.sv
interface hbrp_hdr_if;
  logic                        valid;
  logic                        ready;
  logic [hbrp_pkg::CHAR_W-1:0] ch;
  logic                        final_char;

  modport source (output valid, output ch, output final_char, input ready);
  modport sink   (input valid, input ch, input final_char, output ready);
endinterface

interface hbrp_res_if;
  logic                         valid;
  logic                         ready;
  logic [hbrp_pkg::KIND_W-1:0]  kind;
  logic [hbrp_pkg::VAL_W-1:0]   range_start;
  logic [hbrp_pkg::VAL_W-1:0]   range_stop;
  logic [hbrp_pkg::COUNT_W-1:0] range_number;
  logic                         run_last;

  modport source (output valid, output kind, output range_start, output range_stop,
                  output range_number, output run_last, input ready);
  modport sink   (input valid, input kind, input range_start, input range_stop,
                  input range_number, input run_last, output ready);
endinterface

>>> rtl/http_byte_range_parser.sv
// Byte-range header parser.
// Header characters arrive on the hdr channel, one per transfer, with
// final_char set on the last character of a header. Parsed results leave on
// the res channel: a range (kind 0) as soon as its spec closes, and one
// status (ok, syntax error, none satisfiable) with run_last set after the
// last character. A character yields at most two results.
// The resource length and range_limit are written through
// cfg_we/cfg_index/cfg_data; the user must write them only while the block is
// idle, which the block itself does not enforce. Other indexes are ignored. A
// character is registered at its transfer and parsed in the next cycle; its
// results are then written to the result queue. The block takes one character
// per cycle while hdr.ready is high; the limit is the four-entry result queue,
// which must have room for two results beyond the character in work. When the
// receiver stalls, the queue fills and hdr.ready drops; no result is lost.
// Reset (rst, synchronous) empties the queue, clears the parse state to the
// start of a header, and sets the resource length to 0 and range_limit to 16.
module http_byte_range_parser (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [hbrp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [hbrp_pkg::CFG_W-1:0]     cfg_data,
  hbrp_hdr_if.sink                       hdr,
  hbrp_res_if.source                     res
);
  import hbrp_pkg::*;

  typedef enum logic [2:0] {
    PH_PREFIX, PH_SPEC, PH_SUF0, PH_SUF, PH_FIRST, PH_DASHWS, PH_SECOND, PH_TAIL
  } ph_t;

  typedef struct packed {
    logic             fail;
    logic             closed;
    logic             emit;
    logic [VAL_W-1:0] s;
    logic [VAL_W-1:0] e;
  } close_t;

  typedef struct packed {
    logic             ovf;
    logic [VAL_W-1:0] val;
  } acc_t;

  // Decimal accumulate v*10+d with the overflow check against 2^NUM_W-1.
  function automatic acc_t accum(input logic [VAL_W-1:0] v, input logic [3:0] d);
    logic [VAL_W+3:0] sum;
    acc_t r;
    sum = {1'b0, v, 3'b000} + {3'b000, v, 1'b0} + {{VAL_W{1'b0}}, d};
    r.ovf = |sum[VAL_W+3:NUM_W];
    r.val = sum[VAL_W-1:0];
    return r;
  endfunction

  // Closing a spec from the given phase; also covers a header ending there.
  function automatic close_t close_spec(input ph_t ph, input logic [VAL_W-1:0] fv,
                                        input logic [VAL_W-1:0] sv,
                                        input logic [VAL_W-1:0] fs);
    logic [VAL_W-1:0] fs_m1;
    logic [VAL_W-1:0] suf;
    logic [VAL_W-1:0] e2;
    close_t r;
    r     = '0;
    fs_m1 = fs - VAL_W'(1);
    suf   = (fv > fs) ? fs : fv;
    e2    = (sv >= fs) ? fs_m1 : sv;
    case (ph)
      PH_PREFIX, PH_SUF0, PH_FIRST: r.fail = 1'b1;
      PH_SUF: begin
        if (fv == '0) begin
          r.fail = 1'b1;
        end else begin
          r.closed = 1'b1;
          r.s      = fs - suf;
          r.e      = fs_m1;
          r.emit   = (fs != '0);
        end
      end
      PH_SECOND: begin
        r.closed = 1'b1;
        r.s      = fv;
        r.e      = e2;
        r.emit   = (fv < fs) && (fv <= e2);
      end
      PH_DASHWS: begin
        r.closed = 1'b1;
        r.s      = fv;
        r.e      = fs_m1;
        r.emit   = (fv < fs);
      end
      default: r.fail = 1'b0;
    endcase
    return r;
  endfunction

  // Configuration.
  logic [VAL_W-1:0]   resource_len;
  logic [COUNT_W-1:0] range_limit;

  // Input register.
  logic              item_valid;
  logic [CHAR_W-1:0] item_ch;
  logic              item_final;

  // Parse state.
  ph_t                phase, phase_next;
  logic [POS_W-1:0]   prefix_pos, pos_next;
  logic [VAL_W-1:0]   first_value, first_next;
  logic [VAL_W-1:0]   second_value, second_next;
  logic [COUNT_W-1:0] ranges_kept, kept_next;
  logic               error_seen, err_next;
  logic               stopped, stop_next;

  // State after the character itself, before the end of the header.
  ph_t                s1_phase;
  logic [POS_W-1:0]   s1_pos;
  logic [VAL_W-1:0]   s1_first;
  logic [VAL_W-1:0]   s1_second;
  logic [COUNT_W-1:0] s1_kept;
  logic               s1_err;
  logic               s1_stop;
  logic               s1_nul;
  logic               s1_rng;
  logic [VAL_W-1:0]   s1_rng_s;
  logic [VAL_W-1:0]   s1_rng_e;
  logic [COUNT_W-1:0] s1_rng_n;

  logic               rng_valid;
  logic [VAL_W-1:0]   rng_start;
  logic [VAL_W-1:0]   rng_stop;
  logic [COUNT_W-1:0] rng_num;
  logic               stat_valid;
  logic [KIND_W-1:0]  stat_kind;
  logic [COUNT_W-1:0] stat_num;

  logic [CHAR_W-1:0]  lower_ch;
  logic               is_digit;
  logic               is_ws;
  acc_t               acc_first;
  acc_t               acc_second;
  close_t             cl_feed;
  close_t             cl_end;
  logic               end_req;

  // Result queue.
  result_t            queue [OUT_DEPTH];
  logic [OUT_AW-1:0]  wr_ptr;
  logic [OUT_AW-1:0]  rd_ptr;
  logic [OUT_CW-1:0]  count;
  logic               pop;
  result_t            push0;
  result_t            push1;
  logic [1:0]         push_n;

  assign lower_ch   = (item_ch >= CH_UP_A && item_ch <= CH_UP_Z) ? (item_ch + CH_CASE)
                                                                  : item_ch;
  assign is_digit   = (item_ch >= CH_ZERO) && (item_ch <= CH_NINE);
  assign is_ws      = (item_ch == CH_SPACE) || (item_ch == CH_TAB);
  assign acc_first  = accum(first_value, item_ch[3:0]);
  assign acc_second = accum(second_value, item_ch[3:0]);
  assign cl_feed    = close_spec(phase, first_value, second_value, resource_len);

  // Effect of the character on the parse.
  always_comb begin
    s1_phase  = phase;
    s1_pos    = prefix_pos;
    s1_first  = first_value;
    s1_second = second_value;
    s1_kept   = ranges_kept;
    s1_err    = error_seen;
    s1_stop   = stopped;
    s1_nul    = 1'b0;
    s1_rng    = 1'b0;
    s1_rng_s  = '0;
    s1_rng_e  = '0;
    s1_rng_n  = '0;
    if (item_valid && !stopped) begin
      if (item_ch == CH_NUL) begin
        s1_nul = 1'b1;
      end else begin
        case (phase)
          PH_PREFIX: begin
            if (prefix_pos >= POS_W'(PREFIX_LEN) || lower_ch != prefix_char(prefix_pos)) begin
              s1_err  = 1'b1;
              s1_stop = 1'b1;
            end else begin
              s1_pos = prefix_pos + POS_W'(1);
              if (s1_pos == POS_W'(PREFIX_LEN)) begin
                s1_phase = PH_SPEC;
              end
            end
          end
          PH_SPEC: begin
            if (!is_ws) begin
              s1_first  = '0;
              s1_second = '0;
              if (item_ch == CH_DASH) begin
                s1_phase = PH_SUF0;
              end else if (is_digit) begin
                s1_phase = PH_FIRST;
                s1_first = {{(VAL_W-4){1'b0}}, item_ch[3:0]};
              end else begin
                s1_err  = 1'b1;
                s1_stop = 1'b1;
              end
            end
          end
          PH_SUF0, PH_SUF, PH_FIRST, PH_DASHWS, PH_SECOND: begin
            if (is_digit) begin
              if (phase == PH_SUF0) begin
                s1_phase = PH_SUF;
              end else if (phase == PH_DASHWS) begin
                s1_phase = PH_SECOND;
              end
              if (phase == PH_DASHWS || phase == PH_SECOND) begin
                if (acc_second.ovf) begin
                  s1_err  = 1'b1;
                  s1_stop = 1'b1;
                end else begin
                  s1_second = acc_second.val;
                end
              end else if (acc_first.ovf) begin
                s1_err  = 1'b1;
                s1_stop = 1'b1;
              end else begin
                s1_first = acc_first.val;
              end
            end else if (phase == PH_FIRST && item_ch == CH_DASH) begin
              s1_phase = PH_DASHWS;
            end else if (phase == PH_DASHWS && is_ws) begin
              s1_phase = PH_DASHWS;
            end else if (phase == PH_SUF0 || phase == PH_FIRST) begin
              s1_err  = 1'b1;
              s1_stop = 1'b1;
            end else begin
              // The spec closes here; the same character is then checked as
              // text that follows a spec.
              s1_phase = PH_TAIL;
              if (cl_feed.fail) begin
                s1_err  = 1'b1;
                s1_stop = 1'b1;
              end else if (cl_feed.emit) begin
                s1_rng   = 1'b1;
                s1_rng_s = cl_feed.s;
                s1_rng_e = cl_feed.e;
                s1_rng_n = ranges_kept;
                s1_kept  = ranges_kept + COUNT_W'(1);
                if (s1_kept >= range_limit) begin
                  s1_stop = 1'b1;
                end
              end
              if (!s1_stop) begin
                if (item_ch == CH_COMMA) begin
                  s1_phase = PH_SPEC;
                end else if (!is_ws) begin
                  s1_stop = 1'b1;
                end
              end
            end
          end
          PH_TAIL: begin
            if (item_ch == CH_COMMA) begin
              s1_phase = PH_SPEC;
            end else if (!is_ws) begin
              s1_stop = 1'b1;
            end
          end
          default: s1_stop = stopped;
        endcase
      end
    end
  end

  assign cl_end  = close_spec(s1_phase, s1_first, s1_second, resource_len);
  assign end_req = item_valid && (s1_nul || (item_final && !s1_stop));

  // End of the header text, the status, and the start of the next header.
  always_comb begin
    phase_next  = s1_phase;
    pos_next    = s1_pos;
    first_next  = s1_first;
    second_next = s1_second;
    kept_next   = s1_kept;
    err_next    = s1_err;
    stop_next   = s1_stop;
    rng_valid   = s1_rng;
    rng_start   = s1_rng_s;
    rng_stop    = s1_rng_e;
    rng_num     = s1_rng_n;
    stat_valid  = 1'b0;
    stat_kind   = KIND_OK;
    stat_num    = '0;
    if (end_req) begin
      stop_next = 1'b1;
      if (cl_end.fail) begin
        err_next = 1'b1;
      end else if (cl_end.closed) begin
        phase_next = PH_TAIL;
        if (cl_end.emit) begin
          rng_valid = 1'b1;
          rng_start = cl_end.s;
          rng_stop  = cl_end.e;
          rng_num   = s1_kept;
          kept_next = s1_kept + COUNT_W'(1);
        end
      end
    end
    if (item_valid && item_final) begin
      stat_valid = 1'b1;
      stat_num   = kept_next;
      if (err_next) begin
        stat_kind = KIND_SYNTAX;
      end else if (kept_next == '0) begin
        stat_kind = KIND_UNSAT;
      end else begin
        stat_kind = KIND_OK;
      end
      phase_next  = PH_PREFIX;
      pos_next    = '0;
      first_next  = '0;
      second_next = '0;
      kept_next   = '0;
      err_next    = 1'b0;
      stop_next   = 1'b0;
    end
  end

  // Results of one character in order: the range first, then the status.
  always_comb begin
    result_t rng_res;
    result_t stat_res;
    rng_res.kind          = KIND_RANGE;
    rng_res.range_start   = rng_start;
    rng_res.range_stop    = rng_stop;
    rng_res.range_number  = rng_num;
    rng_res.run_last      = 1'b0;
    stat_res.kind         = stat_kind;
    stat_res.range_start  = '0;
    stat_res.range_stop   = '0;
    stat_res.range_number = stat_num;
    stat_res.run_last     = 1'b1;
    push0  = rng_valid ? rng_res : stat_res;
    push1  = stat_res;
    push_n = {1'b0, rng_valid} + {1'b0, stat_valid};
  end

  // Room for two more results beyond the character now being parsed.
  assign hdr.ready = (count + {1'b0, item_valid, 1'b0}) <= OUT_CW'(OUT_DEPTH - 2);
  assign pop       = res.valid && res.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      resource_len <= '0;
      range_limit  <= RANGE_LIMIT_RST;
      item_valid   <= 1'b0;
      phase        <= PH_PREFIX;
      prefix_pos   <= '0;
      first_value  <= '0;
      second_value <= '0;
      ranges_kept  <= '0;
      error_seen   <= 1'b0;
      stopped      <= 1'b0;
      wr_ptr       <= '0;
      rd_ptr       <= '0;
      count        <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_RES_LEN:     resource_len <= cfg_data[VAL_W-1:0];
          CFG_RANGE_LIMIT: range_limit  <= cfg_data[COUNT_W-1:0];
          default:         range_limit  <= range_limit;
        endcase
      end
      item_valid   <= hdr.valid && hdr.ready;
      phase        <= phase_next;
      prefix_pos   <= pos_next;
      first_value  <= first_next;
      second_value <= second_next;
      ranges_kept  <= kept_next;
      error_seen   <= err_next;
      stopped      <= stop_next;
      wr_ptr       <= wr_ptr + OUT_AW'(push_n);
      rd_ptr       <= rd_ptr + OUT_AW'(pop);
      count        <= count + OUT_CW'(push_n) - OUT_CW'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (hdr.valid && hdr.ready) begin
      item_ch    <= hdr.ch;
      item_final <= hdr.final_char;
    end
    if (push_n != 2'd0) begin
      queue[wr_ptr] <= push0;
    end
    if (push_n == 2'd2) begin
      queue[wr_ptr + OUT_AW'(1)] <= push1;
    end
  end

  assign res.valid        = (count != '0);
  assign res.kind         = queue[rd_ptr].kind;
  assign res.range_start  = queue[rd_ptr].range_start;
  assign res.range_stop   = queue[rd_ptr].range_stop;
  assign res.range_number = queue[rd_ptr].range_number;
  assign res.run_last     = queue[rd_ptr].run_last;

endmodule
